/* rtl/cg_pkg.sv */
`default_nettype none
package cg_pkg;

	localparam int VW = 32;
	localparam int AW = 64;
	localparam int FRAC = 16;
	localparam int IDX_W = 4;
	localparam int MAX_ORDER = 16;
	localparam int MAT_DEPTH = MAX_ORDER * MAX_ORDER;
	localparam int DIV_STEPS = AW + FRAC;
	localparam int DIV_QBITS = VW - 1;

	localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
	localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

	localparam logic [1:0] OP_LD_A = 2'd0;
	localparam logic [1:0] OP_LD_B = 2'd1;
	localparam logic [1:0] OP_LD_X = 2'd2;
	localparam logic [1:0] OP_SOLVE = 2'd3;

	localparam logic [1:0] CFG_SIZE = 2'd0;
	localparam logic [1:0] CFG_TOL = 2'd1;
	localparam logic [1:0] CFG_LIMIT = 2'd2;
	localparam logic [1:0] CFG_PERIOD = 2'd3;

	typedef enum logic [2:0] {
		U_RES = 3'd0,
		U_DAM = 3'd1,
		U_RR  = 3'd2,
		U_DEN = 3'd3,
		U_UX  = 3'd4,
		U_UR  = 3'd5,
		U_RRN = 3'd6,
		U_UD  = 3'd7
	} uop_t;

	typedef struct packed {
		logic [1:0] op;
		logic [3:0] row;
		logic [3:0] col;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [3:0] index;
		logic signed [31:0] component;
		logic last;
		logic [15:0] iterations_done;
	} res_t;

	typedef struct packed {
		uop_t uop;
		logic [IDX_W-1:0] i;
		logic [IDX_W-1:0] j;
		logic load;
		logic mul;
		logic e2;
		logic col;
		logic copy_d;
		logic dot;
		logic tgt_mul;
		logic tgt_src;
		logic tgt_sum;
		logic div_start;
		logic div_sel;
		logic rr_adv;
	} cmd_t;

	typedef struct packed {
		logic acc_zero;
		logic rr_zero;
		logic rr_gt_tgt;
		logic div_done;
	} stat_t;

	function automatic logic signed [VW-1:0] sat_v(input logic signed [VW:0] v);
		if (v[VW] != v[VW-1]) begin
			return v[VW] ? VMIN : VMAX;
		end
		return v[VW-1:0];
	endfunction

	// Q32.32 to Q16.16, round half up, saturate
	function automatic logic signed [VW-1:0] to_q(input logic signed [AW-1:0] v);
		logic [AW:0] t;
		logic [AW-FRAC:0] s;
		t = {v[AW-1], v} + 65'd32768;
		s = t[AW:FRAC];
		if (&s[AW-FRAC:VW-1] || !(|s[AW-FRAC:VW-1])) begin
			return s[VW-1:0];
		end
		return s[AW-FRAC] ? VMIN : VMAX;
	endfunction

	function automatic logic signed [AW-1:0] sadd(input logic signed [AW-1:0] a,
			input logic signed [AW-1:0] b);
		logic [AW:0] s;
		s = {a[AW-1], a} + {b[AW-1], b};
		if (s[AW] != s[AW-1]) begin
			return s[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
		end
		return s[AW-1:0];
	endfunction

endpackage
`default_nettype wire

/* rtl/conjugate_gradient_solver.sv */
`default_nettype none
// Loads are written only while idle. A solve request runs its vector products on one
// shared multiplier (the tolerance target uses a separate pair): matrix-vector passes,
// dots and vector updates, plus 2 divides per iteration; the n results then leave one
// per cycle while res_stall is low. Sustained rate is set by the shared multiplier and
// the bit-serial divider. Reset clears control state and restores register defaults;
// stores hold no defined value until loaded.
module conjugate_gradient_solver (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire cg_pkg::req_t   req,
	output logic                res_valid,
	input  wire logic           res_stall,
	output cg_pkg::res_t        res,
	input  wire logic           cfg_we,
	input  wire logic [1:0]     cfg_index,
	input  wire logic [15:0]    cfg_data
);
	logic [4:0] size_q;
	logic [15:0] tol_q, limit_q, period_q;
	cg_pkg::cmd_t cmd;
	cg_pkg::stat_t stat;
	logic [3:0] res_index;
	logic res_last;
	logic [15:0] iter;
	logic signed [cg_pkg::VW-1:0] component;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= 5'd16;
			tol_q <= 16'd655;
			limit_q <= 16'd1000;
			period_q <= 16'd50;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cg_pkg::CFG_SIZE:   size_q <= cfg_data[4:0];
				cg_pkg::CFG_TOL:    tol_q <= cfg_data;
				cg_pkg::CFG_LIMIT:  limit_q <= cfg_data;
				cg_pkg::CFG_PERIOD: period_q <= cfg_data;
				default: ;
			endcase
		end
	end

	cg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_op    (req.op),
		.req_stall (req_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_index (res_index),
		.res_last  (res_last),
		.iter      (iter),
		.size      (size_q),
		.limit     (limit_q),
		.period    (period_q),
		.stat      (stat),
		.cmd       (cmd)
	);

	cg_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.req       (req),
		.tol       (tol_q),
		.stat      (stat),
		.component (component)
	);

	assign res.index = res_index;
	assign res.component = component;
	assign res.last = res_last;
	assign res.iterations_done = iter;
endmodule
`default_nettype wire

/* rtl/cg_ram.sv */
`default_nettype none
module cg_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* rtl/cg_div.sv */
`default_nettype none
module cg_div (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	input  wire logic signed [cg_pkg::AW-1:0]    num,
	input  wire logic signed [cg_pkg::AW-1:0]    den,
	output logic                                 done,
	output logic signed [cg_pkg::VW-1:0]         quo
);
	localparam int CW = $clog2(cg_pkg::DIV_STEPS);

	logic busy_q;
	logic [CW-1:0] cnt_q;
	logic [cg_pkg::AW-1:0] rem_q;
	logic [cg_pkg::AW-1:0] dsr_q;
	logic [cg_pkg::DIV_STEPS-1:0] dvd_q;
	logic [cg_pkg::DIV_QBITS-1:0] qb_q;
	logic ovf_q;
	logic neg_q;
	logic done_q;
	logic signed [cg_pkg::VW-1:0] quo_q;

	logic [cg_pkg::AW:0] r2;
	logic ge;
	logic [cg_pkg::AW:0] diff;
	logic [cg_pkg::DIV_QBITS-1:0] qf;
	logic of;
	logic [cg_pkg::VW-1:0] mres;

	always_comb begin
		r2 = {rem_q, dvd_q[cg_pkg::DIV_STEPS-1]};
		ge = r2 >= {1'b0, dsr_q};
		diff = r2 - {1'b0, dsr_q};
		qf = {qb_q[cg_pkg::DIV_QBITS-2:0], ge};
		// quotient bits above the Q16.16 range force saturation
		of = ovf_q || (ge && (cnt_q < CW'(cg_pkg::DIV_STEPS - cg_pkg::DIV_QBITS)));
		mres = of ? cg_pkg::VMAX : {1'b0, qf};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(cg_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= den[cg_pkg::AW-1] ? (~den + 1'b1) : den;
			dvd_q <= {(num[cg_pkg::AW-1] ? (~num + 1'b1) : num), {cg_pkg::FRAC{1'b0}}};
			qb_q <= '0;
			ovf_q <= 1'b0;
			neg_q <= num[cg_pkg::AW-1] != den[cg_pkg::AW-1];
		end else if (busy_q) begin
			rem_q <= ge ? diff[cg_pkg::AW-1:0] : r2[cg_pkg::AW-1:0];
			dvd_q <= {dvd_q[cg_pkg::DIV_STEPS-2:0], 1'b0};
			qb_q <= qf;
			ovf_q <= of;
			if (cnt_q == CW'(cg_pkg::DIV_STEPS - 1)) begin
				quo_q <= neg_q ? (~mres + 1'b1) : mres;
			end
		end
	end

	assign done = done_q;
	assign quo = quo_q;
endmodule
`default_nettype wire

/* rtl/cg_datapath.sv */
`default_nettype none
module cg_datapath (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cg_pkg::cmd_t                  cmd,
	input  wire cg_pkg::req_t                  req,
	input  wire logic [15:0]                   tol,
	output cg_pkg::stat_t                      stat,
	output logic signed [cg_pkg::VW-1:0]       component
);
	logic signed [cg_pkg::VW-1:0] x_q  [cg_pkg::MAX_ORDER];
	logic signed [cg_pkg::VW-1:0] b_q  [cg_pkg::MAX_ORDER];
	logic signed [cg_pkg::VW-1:0] r_q  [cg_pkg::MAX_ORDER];
	logic signed [cg_pkg::VW-1:0] d_q  [cg_pkg::MAX_ORDER];
	logic signed [cg_pkg::VW-1:0] da_q [cg_pkg::MAX_ORDER];

	logic signed [cg_pkg::AW-1:0] acc_q, rr_q, rrn_q, den_q, tgt_q;
	logic signed [cg_pkg::AW-1:0] prod_s1;
	logic [47:0] th_s1, tl_s1;

	logic [cg_pkg::VW-1:0] a_rd;
	logic signed [cg_pkg::VW-1:0] ma, mb, qv, colq, newr;
	logic [cg_pkg::AW-1:0] tsrc;
	logic signed [cg_pkg::AW-1:0] dnum, dden;
	logic div_done;
	logic signed [cg_pkg::VW-1:0] scal;

	cg_ram #(.WIDTH(cg_pkg::VW), .DEPTH(cg_pkg::MAT_DEPTH)) u_mat (
		.clk   (clk),
		.we    (cmd.load && (req.op == cg_pkg::OP_LD_A)),
		.waddr ({req.row, req.col}),
		.wdata (req.value),
		.raddr ({cmd.i, cmd.j}),
		.rdata (a_rd)
	);

	assign dnum = cmd.div_sel ? rrn_q : rr_q;
	assign dden = cmd.div_sel ? rr_q : den_q;

	cg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (dnum),
		.den    (dden),
		.done   (div_done),
		.quo    (scal)
	);

	always_comb begin
		case (cmd.uop)
			cg_pkg::U_RES: begin ma = x_q[cmd.i]; mb = a_rd; end
			cg_pkg::U_DAM: begin ma = d_q[cmd.i]; mb = a_rd; end
			cg_pkg::U_DEN: begin ma = d_q[cmd.i]; mb = da_q[cmd.i]; end
			cg_pkg::U_UX:  begin ma = scal; mb = d_q[cmd.i]; end
			cg_pkg::U_UR:  begin ma = scal; mb = da_q[cmd.i]; end
			cg_pkg::U_UD:  begin ma = scal; mb = d_q[cmd.i]; end
			default:       begin ma = r_q[cmd.i]; mb = r_q[cmd.i]; end
		endcase
		qv = cg_pkg::to_q(prod_s1);
		colq = cg_pkg::to_q(acc_q);
		newr = cg_pkg::sat_v({b_q[cmd.j][cg_pkg::VW-1], b_q[cmd.j]} - {colq[cg_pkg::VW-1], colq});
		tsrc = cmd.tgt_src ? tgt_q : rr_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.load && (req.op == cg_pkg::OP_LD_B)) begin
			b_q[req.row] <= req.value;
		end
		if (cmd.load && (req.op == cg_pkg::OP_LD_X)) begin
			x_q[req.row] <= req.value;
		end
		if (cmd.mul) begin
			prod_s1 <= ma * mb;
		end
		if (cmd.e2) begin
			case (cmd.uop)
				cg_pkg::U_UX: x_q[cmd.i] <= cg_pkg::sat_v({x_q[cmd.i][cg_pkg::VW-1], x_q[cmd.i]}
					+ {qv[cg_pkg::VW-1], qv});
				cg_pkg::U_UR: r_q[cmd.i] <= cg_pkg::sat_v({r_q[cmd.i][cg_pkg::VW-1], r_q[cmd.i]}
					- {qv[cg_pkg::VW-1], qv});
				cg_pkg::U_UD: d_q[cmd.i] <= cg_pkg::sat_v({r_q[cmd.i][cg_pkg::VW-1], r_q[cmd.i]}
					+ {qv[cg_pkg::VW-1], qv});
				default: acc_q <= (cmd.i == '0) ? prod_s1 : cg_pkg::sadd(acc_q, prod_s1);
			endcase
		end
		if (cmd.col) begin
			if (cmd.uop == cg_pkg::U_RES) begin
				r_q[cmd.j] <= newr;
				if (cmd.copy_d) begin
					d_q[cmd.j] <= newr;
				end
			end else begin
				da_q[cmd.j] <= colq;
			end
		end
		if (cmd.tgt_mul) begin
			th_s1 <= {16'd0, tsrc[63:32]} * {32'd0, tol};
			tl_s1 <= {16'd0, tsrc[31:0]} * {32'd0, tol};
		end
		if (cmd.tgt_sum) begin
			tgt_q <= {th_s1, 16'd0} + {32'd0, tl_s1[47:16]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rr_q <= '0;
			rrn_q <= '0;
			den_q <= '0;
		end else begin
			if (cmd.dot) begin
				case (cmd.uop)
					cg_pkg::U_RR:  rr_q <= acc_q;
					cg_pkg::U_RRN: rrn_q <= acc_q;
					default:       den_q <= acc_q;
				endcase
			end
			if (cmd.rr_adv) begin
				rr_q <= rrn_q;
			end
		end
	end

	assign stat.acc_zero = acc_q == '0;
	assign stat.rr_zero = rr_q == '0;
	assign stat.rr_gt_tgt = rr_q > tgt_q;
	assign stat.div_done = div_done;
	assign component = x_q[cmd.i];
endmodule
`default_nettype wire

/* rtl/cg_ctrl.sv */
`default_nettype none
module cg_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 req_valid,
	input  wire logic [1:0]           req_op,
	output logic                      req_stall,
	output logic                      res_valid,
	input  wire logic                 res_stall,
	output logic [3:0]                res_index,
	output logic                      res_last,
	output logic [15:0]               iter,
	input  wire logic [4:0]           size,
	input  wire logic [15:0]          limit,
	input  wire logic [15:0]          period,
	input  wire cg_pkg::stat_t        stat,
	output cg_pkg::cmd_t              cmd
);
	typedef enum logic [11:0] {
		S_IDLE = 12'b000000000001,
		S_E0   = 12'b000000000010,
		S_E1   = 12'b000000000100,
		S_E2   = 12'b000000001000,
		S_COL  = 12'b000000010000,
		S_DOTW = 12'b000000100000,
		S_TG1  = 12'b000001000000,
		S_TG2  = 12'b000010000000,
		S_CHK  = 12'b000100000000,
		S_DIVS = 12'b001000000000,
		S_DIVW = 12'b010000000000,
		S_OUT  = 12'b100000000000
	} state_t;

	state_t st_q;
	cg_pkg::uop_t uop_q;
	logic [cg_pkg::IDX_W-1:0] i_q, j_q, nm1;
	logic init_q, pass_q, dsel_q;
	logic [15:0] iter_q, rst_q;
	logic last_i, is_mat, is_dot, fin_go;

	always_comb begin
		if (size == 5'd0) begin
			nm1 = '0;
		end else if (size > 5'(cg_pkg::MAX_ORDER)) begin
			nm1 = 4'(cg_pkg::MAX_ORDER - 1);
		end else begin
			nm1 = 4'(size - 5'd1);
		end
		last_i = i_q == nm1;
		is_mat = (uop_q == cg_pkg::U_RES) || (uop_q == cg_pkg::U_DAM);
		is_dot = (uop_q == cg_pkg::U_RR) || (uop_q == cg_pkg::U_RRN) ||
			(uop_q == cg_pkg::U_DEN);
		fin_go = ((st_q == S_E2) && last_i && !is_mat && !is_dot) ||
			((st_q == S_COL) && (j_q == nm1)) || (st_q == S_DOTW);
	end

	always_comb begin
		cmd = '0;
		cmd.uop = uop_q;
		cmd.i = i_q;
		cmd.j = j_q;
		cmd.load = (st_q == S_IDLE) && req_valid && (req_op != cg_pkg::OP_SOLVE);
		cmd.mul = st_q == S_E1;
		cmd.e2 = st_q == S_E2;
		cmd.col = st_q == S_COL;
		cmd.copy_d = init_q;
		cmd.dot = st_q == S_DOTW;
		cmd.tgt_mul = st_q == S_TG1;
		cmd.tgt_src = pass_q;
		cmd.tgt_sum = st_q == S_TG2;
		cmd.div_start = st_q == S_DIVS;
		cmd.div_sel = dsel_q;
		cmd.rr_adv = (st_q == S_E2) && last_i && (uop_q == cg_pkg::U_UD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			uop_q <= cg_pkg::U_RES;
			i_q <= '0;
			j_q <= '0;
			init_q <= 1'b0;
			pass_q <= 1'b0;
			dsel_q <= 1'b0;
			iter_q <= '0;
			rst_q <= '0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (req_valid && (req_op == cg_pkg::OP_SOLVE)) begin
						st_q <= S_E0;
						uop_q <= cg_pkg::U_RES;
						init_q <= 1'b1;
						i_q <= '0;
						j_q <= '0;
						iter_q <= '0;
						rst_q <= '0;
					end
				end
				S_E0: st_q <= S_E1;
				S_E1: st_q <= S_E2;
				S_E2: begin
					if (!last_i) begin
						i_q <= i_q + 1'b1;
						st_q <= S_E0;
					end else if (is_mat) begin
						st_q <= S_COL;
					end else if (is_dot) begin
						st_q <= S_DOTW;
					end
				end
				S_COL: begin
					if (j_q != nm1) begin
						j_q <= j_q + 1'b1;
						i_q <= '0;
						st_q <= S_E0;
					end
				end
				S_DOTW: ;
				S_TG1: st_q <= S_TG2;
				S_TG2: begin
					pass_q <= !pass_q;
					st_q <= pass_q ? S_CHK : S_TG1;
				end
				S_CHK: begin
					i_q <= '0;
					if ((iter_q < limit) && stat.rr_gt_tgt) begin
						uop_q <= cg_pkg::U_DAM;
						st_q <= S_E0;
					end else begin
						st_q <= S_OUT;
					end
				end
				S_DIVS: st_q <= S_DIVW;
				S_DIVW: begin
					if (stat.div_done) begin
						uop_q <= dsel_q ? cg_pkg::U_UD : cg_pkg::U_UX;
						st_q <= S_E0;
					end
				end
				S_OUT: begin
					if (!res_stall) begin
						if (last_i) begin
							st_q <= S_IDLE;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase

			// pick the next pass once the current vector pass completes
			if (fin_go) begin
				i_q <= '0;
				j_q <= '0;
				case (uop_q)
					cg_pkg::U_RES: begin
						uop_q <= init_q ? cg_pkg::U_RR : cg_pkg::U_RRN;
						st_q <= S_E0;
					end
					cg_pkg::U_DAM: begin
						uop_q <= cg_pkg::U_DEN;
						st_q <= S_E0;
					end
					cg_pkg::U_RR: begin
						pass_q <= 1'b0;
						st_q <= S_TG1;
					end
					cg_pkg::U_DEN: begin
						dsel_q <= 1'b0;
						st_q <= stat.acc_zero ? S_OUT : S_DIVS;
					end
					cg_pkg::U_UX: begin
						st_q <= S_E0;
						if (rst_q == period) begin
							rst_q <= '0;
							init_q <= 1'b0;
							uop_q <= cg_pkg::U_RES;
						end else begin
							uop_q <= cg_pkg::U_UR;
						end
					end
					cg_pkg::U_UR: begin
						uop_q <= cg_pkg::U_RRN;
						st_q <= S_E0;
					end
					cg_pkg::U_RRN: begin
						dsel_q <= 1'b1;
						st_q <= stat.rr_zero ? S_OUT : S_DIVS;
					end
					default: begin
						iter_q <= iter_q + 1'b1;
						rst_q <= rst_q + 1'b1;
						st_q <= S_CHK;
					end
				endcase
			end
		end
	end

	assign req_stall = st_q != S_IDLE;
	assign res_valid = st_q == S_OUT;
	assign res_index = i_q;
	assign res_last = last_i;
	assign iter = iter_q;
endmodule
`default_nettype wire
